/* design/hed_pkg.sv */
// Shared types, entity tables and controller/datapath interface for the entity decoder.
package hed_pkg;

  localparam int NameCount = 18;
  localparam int NameMax   = 7;
  localparam int OutMax    = 8;
  localparam int BufDepth  = 8;

  localparam logic [7:0]           AmpChar  = 8'h26;
  localparam logic [NameCount-1:0] AllNames = {NameCount{1'b1}};

  typedef struct packed {
    logic [7:0] in_byte;
    logic       segment_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       segment_done;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic feed;
    logic abandon;
    logic close;
    logic send_start;
    logic send_next;
    logic bare;
  } dp_cmd_t;

  typedef struct packed {
    logic queue_empty;
    logic in_entity;
    logic seg_end;
    logic out_empty;
    logic send_last;
  } dp_status_t;

  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } name_code_t;

  function automatic logic [8*NameMax-1:0] name_str(input logic [4:0] k);
    logic [8*NameMax-1:0] s;
    case (k)
      5'd0:    s = "Auml;  ";
      5'd1:    s = "auml;  ";
      5'd2:    s = "Atilde;";
      5'd3:    s = "atilde;";
      5'd4:    s = "Ouml;  ";
      5'd5:    s = "ouml;  ";
      5'd6:    s = "Aring; ";
      5'd7:    s = "aring; ";
      5'd8:    s = "Uuml;  ";
      5'd9:    s = "uuml;  ";
      5'd10:   s = "Eacute;";
      5'd11:   s = "eacute;";
      5'd12:   s = "curren;";
      5'd13:   s = "quot;  ";
      5'd14:   s = "amp;   ";
      5'd15:   s = "apos;  ";
      5'd16:   s = "gt;    ";
      5'd17:   s = "lt;    ";
      default: s = "       ";
    endcase
    return s;
  endfunction

  function automatic logic [2:0] ent_len(input logic [4:0] k);
    logic [2:0] n;
    case (k)
      5'd2, 5'd3, 5'd10, 5'd11, 5'd12: n = 3'd7;
      5'd6, 5'd7:                      n = 3'd6;
      5'd14:                           n = 3'd4;
      5'd16, 5'd17:                    n = 3'd3;
      default:                         n = 3'd5;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] name_char(input logic [4:0] k, input logic [2:0] idx);
    logic [8*NameMax-1:0] s;
    s = name_str(k);
    return s[8*(NameMax-1-int'(idx)) +: 8];
  endfunction

  function automatic name_code_t name_code(input logic [4:0] k);
    name_code_t c;
    c.two = 1'b1;
    c.b0  = 8'hc3;
    c.b1  = 8'h00;
    case (k)
      5'd0:    c.b1 = 8'h84;
      5'd1:    c.b1 = 8'ha4;
      5'd2:    c.b1 = 8'h83;
      5'd3:    c.b1 = 8'ha3;
      5'd4:    c.b1 = 8'h96;
      5'd5:    c.b1 = 8'hb6;
      5'd6:    c.b1 = 8'h85;
      5'd7:    c.b1 = 8'ha5;
      5'd8:    c.b1 = 8'h9c;
      5'd9:    c.b1 = 8'hbc;
      5'd10:   c.b1 = 8'h89;
      5'd11:   c.b1 = 8'ha9;
      5'd12: begin
        c.b0 = 8'hc2;
        c.b1 = 8'ha4;
      end
      5'd13: begin
        c.two = 1'b0;
        c.b0  = 8'h22;
      end
      5'd14: begin
        c.two = 1'b0;
        c.b0  = 8'h26;
      end
      5'd15: begin
        c.two = 1'b0;
        c.b0  = 8'h27;
      end
      5'd16: begin
        c.two = 1'b0;
        c.b0  = 8'h3e;
      end
      5'd17: begin
        c.two = 1'b0;
        c.b0  = 8'h3c;
      end
      default: c.two = 1'b0;
    endcase
    return c;
  endfunction

endpackage

/* design/hed_datapath.sv */
// Byte ring, entity matcher and result buffer of the entity decoder.
module hed_datapath (
  input  logic               clk,
  input  logic               rst,
  input  hed_pkg::in_item_t  text_item,
  input  hed_pkg::dp_cmd_t   cmd,
  output hed_pkg::dp_status_t status,
  output hed_pkg::out_item_t char_item
);

  logic [7:0] ring [hed_pkg::BufDepth];
  logic [2:0] head;
  logic [2:0] head_next;
  logic [2:0] pend;
  logic [2:0] pend_next;
  logic [3:0] total;
  logic [3:0] total_next;
  logic       in_entity;
  logic       in_entity_next;
  logic [hed_pkg::NameCount-1:0] mask;
  logic [hed_pkg::NameCount-1:0] mask_next;
  logic       seg_flag;

  logic [7:0] out_buf [hed_pkg::OutMax];
  logic [3:0] out_cnt;
  logic [3:0] out_cnt_next;
  logic [2:0] rd_idx;

  logic [2:0] feed_ptr;
  logic [7:0] feed_byte;
  logic [hed_pkg::NameCount-1:0] hit;
  logic [hed_pkg::NameCount-1:0] done_hit;
  hed_pkg::name_code_t hit_code;
  logic [3:0] step;
  logic [1:0] emit_n;
  logic [7:0] emit_b0;
  logic [7:0] emit_b1;
  logic [3:0] out_cnt_inc;
  logic       send_last;

  assign feed_ptr  = head + pend;
  assign feed_byte = ring[feed_ptr];

  always_comb begin
    hit      = '0;
    done_hit = '0;
    hit_code = '0;
    for (int k = 0; k < hed_pkg::NameCount; k++) begin
      hit[k] = mask[k] && (pend < hed_pkg::ent_len(5'(k))) &&
               (hed_pkg::name_char(5'(k), pend) == feed_byte);
      done_hit[k] = hit[k] && ({1'b0, hed_pkg::ent_len(5'(k))} == {1'b0, pend} + 4'd1);
    end
    for (int k = hed_pkg::NameCount - 1; k >= 0; k--) begin
      if (done_hit[k]) begin
        hit_code = hed_pkg::name_code(5'(k));
      end
    end
  end

  always_comb begin
    head_next      = head;
    pend_next      = pend;
    total_next     = total;
    in_entity_next = in_entity;
    mask_next      = mask;
    step           = 4'd0;
    emit_n         = 2'd0;
    emit_b0        = feed_byte;
    emit_b1        = 8'h00;
    if (cmd.load) begin
      total_next = total + 4'd1;
    end else if (cmd.feed) begin
      if (!in_entity) begin
        step = 4'd1;
        if (feed_byte == hed_pkg::AmpChar) begin
          in_entity_next = 1'b1;
          mask_next      = hed_pkg::AllNames;
        end else begin
          emit_n = 2'd1;
        end
      end else if (|done_hit) begin
        step           = {1'b0, pend} + 4'd1;
        pend_next      = 3'd0;
        in_entity_next = 1'b0;
        mask_next      = hed_pkg::AllNames;
        emit_n         = hit_code.two ? 2'd2 : 2'd1;
        emit_b0        = hit_code.b0;
        emit_b1        = hit_code.b1;
      end else if (hit == '0) begin
        step           = 4'd1;
        pend_next      = 3'd0;
        in_entity_next = 1'b0;
        mask_next      = hed_pkg::AllNames;
      end else begin
        pend_next = pend + 3'd1;
        mask_next = hit;
      end
      head_next  = head + step[2:0];
      total_next = total - step;
    end else if (cmd.abandon) begin
      step           = (pend != 3'd0) ? 4'd1 : 4'd0;
      head_next      = head + step[2:0];
      total_next     = total - step;
      pend_next      = 3'd0;
      in_entity_next = 1'b0;
      mask_next      = hed_pkg::AllNames;
    end else if (cmd.close) begin
      total_next     = 4'd0;
      pend_next      = 3'd0;
      in_entity_next = 1'b0;
      mask_next      = hed_pkg::AllNames;
    end
  end

  always_comb begin
    out_cnt_inc  = out_cnt + {2'b00, emit_n};
    out_cnt_next = (out_cnt_inc > 4'(hed_pkg::OutMax)) ? 4'(hed_pkg::OutMax) : out_cnt_inc;
    if (cmd.load) begin
      out_cnt_next = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= 3'd0;
      pend      <= 3'd0;
      total     <= 4'd0;
      in_entity <= 1'b0;
      mask      <= hed_pkg::AllNames;
      out_cnt   <= 4'd0;
      rd_idx    <= 3'd0;
      seg_flag  <= 1'b0;
    end else begin
      head      <= head_next;
      pend      <= pend_next;
      total     <= total_next;
      in_entity <= in_entity_next;
      mask      <= mask_next;
      out_cnt   <= out_cnt_next;
      if (cmd.load) begin
        seg_flag <= text_item.segment_end;
      end
      if (cmd.send_start) begin
        rd_idx <= 3'd0;
      end else if (cmd.send_next) begin
        rd_idx <= rd_idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ring[head + total[2:0]] <= text_item.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < hed_pkg::OutMax; i++) begin
      if (emit_n != 2'd0 && 4'(i) == out_cnt) begin
        out_buf[i] <= emit_b0;
      end else if (emit_n == 2'd2 && 4'(i) == out_cnt + 4'd1) begin
        out_buf[i] <= emit_b1;
      end
    end
  end

  assign send_last = ({1'b0, rd_idx} + 4'd1 == out_cnt);

  assign status.queue_empty = (total == {1'b0, pend});
  assign status.in_entity   = in_entity;
  assign status.seg_end     = seg_flag;
  assign status.out_empty   = (out_cnt == 4'd0);
  assign status.send_last   = send_last;

  always_comb begin
    if (cmd.bare) begin
      char_item.out_byte     = 8'h00;
      char_item.byte_valid   = 1'b0;
      char_item.segment_done = 1'b1;
      char_item.run_last     = 1'b1;
    end else begin
      char_item.out_byte     = out_buf[rd_idx];
      char_item.byte_valid   = 1'b1;
      char_item.segment_done = seg_flag && send_last;
      char_item.run_last     = send_last;
    end
  end

endmodule

/* design/hed_ctrl.sv */
// Sequencing state machine of the entity decoder.
module hed_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                text_valid,
  output logic                text_ready,
  output logic                char_valid,
  input  logic                char_ready,
  input  hed_pkg::dp_status_t status,
  output hed_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WORK = 4'b0010,
    ST_SEND = 4'b0100,
    ST_BARE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign text_ready = (state == ST_IDLE);
  assign char_valid = (state == ST_SEND) || (state == ST_BARE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    cmd.bare   = (state == ST_BARE);
    case (state)
      ST_IDLE: begin
        if (text_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_WORK;
        end
      end
      ST_WORK: begin
        if (!status.queue_empty) begin
          cmd.feed = 1'b1;
        end else if (status.seg_end && status.in_entity) begin
          cmd.abandon = 1'b1;
        end else begin
          cmd.close = status.seg_end;
          if (!status.out_empty) begin
            cmd.send_start = 1'b1;
            state_next     = ST_SEND;
          end else if (status.seg_end) begin
            state_next = ST_BARE;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_SEND: begin
        if (char_ready) begin
          if (status.send_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.send_next = 1'b1;
          end
        end
      end
      ST_BARE: begin
        if (char_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(text_ready && char_valid))
    else $error("input taken while a result is offered");

  a_load_queues: assert property (@(posedge clk) disable iff (rst)
    (text_valid && text_ready) |=> (state == ST_WORK && !status.queue_empty))
    else $error("accepted item not queued");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEND && char_ready && status.send_last) |=> text_ready)
    else $error("no return to idle after last result");

  a_send_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEND) |-> !status.out_empty)
    else $error("sending from an empty result buffer");
`endif

endmodule

/* design/html_entity_decoder.sv */
// Steps: the item is taken, then each byte is fed to the matcher (the item plus
// bytes replayed after a mismatch), each entity still open at segment end is
// abandoned, the item is closed, then its results are sent. No new item is taken
// until every result of the previous item has been sent.
// Reset: synchronous; clears the controller, entity state and counts, not byte buffers.
// Top level of the named entity to UTF-8 decoder.
module html_entity_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               text_valid,
  output logic               text_ready,
  input  hed_pkg::in_item_t  text_item,
  output logic               char_valid,
  input  logic               char_ready,
  output hed_pkg::out_item_t char_item
);

  hed_pkg::dp_cmd_t    cmd;
  hed_pkg::dp_status_t status;

  hed_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .status     (status),
    .cmd        (cmd)
  );

  hed_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .text_item (text_item),
    .cmd       (cmd),
    .status    (status),
    .char_item (char_item)
  );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the named entity to UTF-8 decoder with its own decoding predictor.
module tb_top;

  localparam logic [7:0] SemiChar = 8'h3b;
  localparam int         EntCount = 18;

  logic               clk = 1'b0;
  logic               rst;
  logic               text_valid;
  logic               text_ready;
  hed_pkg::in_item_t  text_item;
  logic               char_valid;
  logic               char_ready = 1'b0;
  hed_pkg::out_item_t char_item;

  html_entity_decoder u_dut (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text_item  (text_item),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  string ent_name [EntCount] = '{
    "Auml;", "auml;", "Atilde;", "atilde;", "Ouml;", "ouml;", "Aring;", "aring;",
    "Uuml;", "uuml;", "Eacute;", "eacute;", "curren;", "quot;", "amp;", "apos;",
    "gt;", "lt;"
  };
  logic [7:0] ent_b0 [EntCount] = '{
    8'hc3, 8'hc3, 8'hc3, 8'hc3, 8'hc3, 8'hc3, 8'hc3, 8'hc3, 8'hc3, 8'hc3,
    8'hc3, 8'hc3, 8'hc2, 8'h22, 8'h26, 8'h27, 8'h3e, 8'h3c
  };
  logic [7:0] ent_b1 [EntCount] = '{
    8'h84, 8'ha4, 8'h83, 8'ha3, 8'h96, 8'hb6, 8'h85, 8'ha5, 8'h9c, 8'hbc,
    8'h89, 8'ha9, 8'ha4, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Predictor state
  logic [7:0]          pend_bytes [hed_pkg::NameMax];
  int                  pend_cnt;
  bit                  ent_open;
  logic [EntCount-1:0] cand_mask;
  logic [7:0]          replay_q [$];
  logic [7:0]          emit_q [$];

  hed_pkg::out_item_t exp_chars [$];
  int        fail_count = 0;
  int        item_count = 0;
  int        result_count = 0;
  int        tx_idle_pct = 21;
  int        rx_idle_pct = 88;

  function automatic void ent_close();
    ent_open  = 1'b0;
    pend_cnt  = 0;
    cand_mask = '1;
  endfunction

  // Drop the ampersand and first collected byte, replay the rest ahead of the queue.
  function automatic void ent_abandon();
    logic [7:0] tmp [$];
    for (int i = 1; i < pend_cnt && i < hed_pkg::NameMax; i++) tmp.push_back(pend_bytes[i]);
    foreach (replay_q[i]) tmp.push_back(replay_q[i]);
    while (tmp.size() > 16) void'(tmp.pop_back());
    replay_q = tmp;
    ent_close();
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    if (emit_q.size() < hed_pkg::OutMax) emit_q.push_back(b);
  endfunction

  function automatic void match_byte(logic [7:0] b);
    int                  idx;
    logic [EntCount-1:0] mask;
    idx  = pend_cnt;
    mask = '0;
    if (!ent_open) begin
      if (b == hed_pkg::AmpChar) begin
        ent_open  = 1'b1;
        pend_cnt  = 0;
        cand_mask = '1;
      end else begin
        emit_byte(b);
      end
      return;
    end
    if (idx >= hed_pkg::NameMax) begin
      ent_abandon();
      return;
    end
    pend_bytes[idx] = b;
    pend_cnt = idx + 1;
    for (int k = 0; k < EntCount; k++) begin
      if (cand_mask[k] && idx < ent_name[k].len() && ent_name[k][idx] == b) mask[k] = 1'b1;
    end
    cand_mask = mask;
    for (int k = 0; k < EntCount; k++) begin
      if (mask[k] && ent_name[k].len() == idx + 1) begin
        emit_byte(ent_b0[k]);
        if (k <= 12) emit_byte(ent_b1[k]);
        ent_close();
        return;
      end
    end
    if (mask == '0) ent_abandon();
  endfunction

  function automatic void decode_item(hed_pkg::in_item_t it);
    hed_pkg::out_item_t r;
    emit_q.delete();
    replay_q.delete();
    replay_q.push_back(it.in_byte);
    forever begin
      while (replay_q.size() > 0) match_byte(replay_q.pop_front());
      if (it.segment_end && ent_open) ent_abandon();
      else break;
    end
    if (it.segment_end) ent_close();
    if (emit_q.size() == 0) begin
      if (it.segment_end) begin
        r = '{out_byte: 8'h00, byte_valid: 1'b0, segment_done: 1'b1, run_last: 1'b1};
        exp_chars.push_back(r);
      end
    end else begin
      foreach (emit_q[i]) begin
        r.out_byte     = emit_q[i];
        r.byte_valid   = 1'b1;
        r.run_last     = (i == emit_q.size() - 1);
        r.segment_done = it.segment_end && r.run_last;
        exp_chars.push_back(r);
      end
    end
  endfunction

  always @(posedge clk) begin
    char_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    hed_pkg::out_item_t e;
    if (!rst && char_valid === 1'b1 && char_ready) begin
      result_count++;
      if (exp_chars.size() == 0) begin
        $error("unexpected result: out_byte %h", char_item.out_byte);
        fail_count++;
      end else begin
        e = exp_chars.pop_front();
        if (char_item.out_byte !== e.out_byte) begin
          $error("out_byte: expected %h, actual %h", e.out_byte, char_item.out_byte);
          fail_count++;
        end
        if (char_item.byte_valid !== e.byte_valid) begin
          $error("byte_valid: expected %b, actual %b", e.byte_valid, char_item.byte_valid);
          fail_count++;
        end
        if (char_item.segment_done !== e.segment_done) begin
          $error("segment_done: expected %b, actual %b", e.segment_done,
                 char_item.segment_done);
          fail_count++;
        end
        if (char_item.run_last !== e.run_last) begin
          $error("run_last: expected %b, actual %b", e.run_last, char_item.run_last);
          fail_count++;
        end
      end
    end
  end

  task automatic send_item(hed_pkg::in_item_t it);
    if ($urandom_range(99) < tx_idle_pct) begin
      text_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    text_valid <= 1'b1;
    text_item  <= it;
    do @(posedge clk); while (!text_ready);
    decode_item(it);
    item_count++;
  endtask

  task automatic send_byte(logic [7:0] b, logic seg);
    hed_pkg::in_item_t it;
    it.in_byte     = b;
    it.segment_end = seg;
    send_item(it);
  endtask

  task automatic send_text(string s, logic seg_at_end);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], seg_at_end && (i == s.len() - 1));
  endtask

  // Hold off the sender until every expected result has come.
  task automatic hold_until_drained();
    text_valid <= 1'b0;
    while (exp_chars.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic test_byte_extremes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
  endtask

  task automatic test_bare_ampersand();
    send_byte(hed_pkg::AmpChar, 1'b1);
  endtask

  task automatic test_short_and_long_names();
    send_text("&gt;", 1'b0);
    send_text("&Atilde;", 1'b0);
  endtask

  task automatic test_replayed_ampersand();
    send_text("&a&gt;", 1'b0);
  endtask

  task automatic test_truncated_at_segment_end();
    send_text("&cur", 1'b1);
  endtask

  task automatic test_random_traffic(int tx_pct, int rx_pct, int n);
    int         start;
    int         sel;
    int         k;
    int         p;
    int         m;
    bit         paused;
    string      nm;
    logic [7:0] b;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start  = item_count;
    paused = 1'b0;
    while (item_count - start < n) begin
      if (!paused && item_count - start >= n / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
      sel = $urandom_range(99);
      k   = $urandom_range(EntCount - 1);
      nm  = ent_name[k];
      if (sel < 25) begin
        send_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
      end else if (sel < 55) begin
        send_byte(hed_pkg::AmpChar, 1'b0);
        send_text(nm, $urandom_range(5) == 0);
      end else if (sel < 70) begin
        p = $urandom_range(nm.len() - 1);
        send_byte(hed_pkg::AmpChar, 1'b0);
        for (int i = 0; i < p; i++) send_byte(nm[i], 1'b0);
        send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
      end else if (sel < 80) begin
        p = $urandom_range(nm.len() - 1);
        send_byte(hed_pkg::AmpChar, p == 0);
        for (int i = 0; i < p; i++) send_byte(nm[i], i == p - 1);
      end else if (sel < 88) begin
        send_byte(hed_pkg::AmpChar, 1'b0);
        send_byte(hed_pkg::AmpChar, 1'b0);
        send_text(nm, $urandom_range(3) == 0);
      end else begin
        m = $urandom_range(1, 8);
        for (int i = 0; i < m; i++) begin
          case ($urandom_range(3))
            0:       b = hed_pkg::AmpChar;
            1:       b = SemiChar;
            2:       b = nm[$urandom_range(nm.len() - 1)];
            default: b = 8'($urandom_range(255));
          endcase
          send_byte(b, $urandom_range(11) == 0);
        end
      end
    end
    hold_until_drained();
  endtask

  initial begin
    rst        = 1'b1;
    text_valid = 1'b0;
    text_item  = '0;
    ent_close();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_byte_extremes();
    test_bare_ampersand();
    test_short_and_long_names();
    test_replayed_ampersand();
    test_truncated_at_segment_end();
    hold_until_drained();
    test_random_traffic(21, 88, 160);
    test_random_traffic(88, 21, 160);
    test_random_traffic(0, 0, 160);
    $display("Sent %0d text items and checked %0d results: plain bytes, all entity names,",
             item_count, result_count);
    $display("broken and truncated entities with replay, bare segment ends, three idle mixes.");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* files.f */
design/hed_pkg.sv
design/hed_datapath.sv
design/hed_ctrl.sv
design/html_entity_decoder.sv
verif/tb_top.sv
